@@ hw/rtl/pmm_pkg.sv @@
// Package for the paged memory manager: request and status codes, fixed
// geometry constants and default sizes. Has no dependencies.

package pmm_pkg;

  localparam int unsigned MEM_BYTES_DFLT = 16384;
  localparam int unsigned PAGES_DFLT     = 64;
  localparam int unsigned PROCESSES_DFLT = 64;

  localparam int unsigned PAGE_BYTES     = 256;
  localparam int unsigned TABLE_PTR_BASE = 64;
  localparam int unsigned VIRT_PAGES     = 64;
  localparam int unsigned RAW_AW         = 16;

  localparam logic [1:0] REQ_NEW   = 2'd0;
  localparam logic [1:0] REQ_KILL  = 2'd1;
  localparam logic [1:0] REQ_STORE = 2'd2;
  localparam logic [1:0] REQ_LOAD  = 2'd3;

  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_NO_TABLE  = 2'd1;
  localparam logic [1:0] STS_NO_DATA   = 2'd2;
  localparam logic [1:0] STS_NO_KILL   = 2'd3;

endpackage

@@ hw/rtl/paged_memory_manager_unit.sv @@
// Top level of the paged memory manager: byte memory, sequencer and the
// shared subtract/compare unit. Depends on pmm_pkg.
//
//   channel   dir  tdata fields (low bit first)                 tuser
//   s_axis    in   process_id, num_pages, virt_addr, store_data  req_type
//   m_axis    out  status, phys_addr, load_data                 -
//
// After reset the byte memory is cleared and no beat is accepted until the clear is
// done. A store or a load passes through the pointer read, the table read and the
// data access in turn, bound by the dependent reads of the single memory port.
// Allocation probes the free map page by page with a read and a check state, and
// the first-fit search restarts at page zero for every page; a kill reads and frees
// each table entry in turn. A finished result waits in the output register while
// the next beat is accepted; a stalled output holds only the item behind it.

module paged_memory_manager_unit
  import pmm_pkg::*;
#(
  parameter int unsigned MEM_BYTES = MEM_BYTES_DFLT,
  parameter int unsigned PAGES     = PAGES_DFLT,
  parameter int unsigned PROCESSES = PROCESSES_DFLT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // process_id[5:0], num_pages[12:6], virt_addr[26:13], store_data[34:27]
  input  logic [39:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], phys_addr[15:2], load_data[23:16]
  output logic [23:0] m_axis_tdata
);

  localparam int unsigned AW      = $clog2(MEM_BYTES);
  localparam int unsigned PGW     = $clog2(PAGES);
  localparam bit          MEM_POW2 = ((MEM_BYTES & (MEM_BYTES - 1)) == 0);

  localparam logic [4:0] S_CLEAR    = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_PID      = 5'd2;
  localparam logic [4:0] S_PTR_RD   = 5'd3;
  localparam logic [4:0] S_PTR_WT   = 5'd4;
  localparam logic [4:0] S_SCAN_RD  = 5'd5;
  localparam logic [4:0] S_SCAN_CHK = 5'd6;
  localparam logic [4:0] S_PTR_WR   = 5'd7;
  localparam logic [4:0] S_ENT_WR   = 5'd8;
  localparam logic [4:0] S_RED      = 5'd9;
  localparam logic [4:0] S_TBL_RD   = 5'd10;
  localparam logic [4:0] S_TBL_WT   = 5'd11;
  localparam logic [4:0] S_DAT      = 5'd12;
  localparam logic [4:0] S_DAT_WT   = 5'd13;
  localparam logic [4:0] S_KILL_RD  = 5'd14;
  localparam logic [4:0] S_KILL_WT  = 5'd15;
  localparam logic [4:0] S_FREE_TBL = 5'd16;
  localparam logic [4:0] S_CLR_PTR  = 5'd17;
  localparam logic [4:0] S_DONE     = 5'd18;

  logic [4:0]        state_q, state_d, ret_q, ret_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [1:0]        req_q, req_d;
  logic [5:0]        pid_q, pid_d;
  logic [6:0]        count_q, count_d;
  logic [13:0]       vaddr_q, vaddr_d;
  logic [7:0]        sdata_q, sdata_d;
  logic [RAW_AW-1:0] addr_q, addr_d;
  logic [PGW-1:0]    scan_q, scan_d;
  logic              phase_tbl_q, phase_tbl_d;
  logic [7:0]        tbl_q, tbl_d;
  logic [PGW-1:0]    page_q, page_d;
  logic [6:0]        idx_q, idx_d;
  logic [1:0]        status_q, status_d;
  logic [13:0]       phys_q, phys_d;
  logic [7:0]        ldata_q, ldata_d;

  logic              out_valid_q, out_valid_d;
  logic [1:0]        out_status_q, out_status_d;
  logic [13:0]       out_phys_q, out_phys_d;
  logic [7:0]        out_ldata_q, out_ldata_d;

  logic [7:0]        mem_q [MEM_BYTES];
  logic [7:0]        rdata_q;
  logic [AW-1:0]     mem_idx;
  logic              mem_we;
  logic [7:0]        mem_wdata;

  logic [RAW_AW:0]   alu_a, alu_b, alu_diff;
  logic              alu_ge;
  logic [AW-1:0]     ptr_idx;
  logic [RAW_AW-1:0] raw_addr;

  // Shared subtract and compare unit for the process number and address wrap.
  always_comb begin
    if (state_q == S_PID) begin
      alu_a = (RAW_AW + 1)'(pid_q);
      alu_b = (RAW_AW + 1)'(PROCESSES);
    end else begin
      alu_a = (RAW_AW + 1)'(addr_q);
      alu_b = (RAW_AW + 1)'(MEM_BYTES);
    end
    alu_diff = alu_a - alu_b;
    alu_ge   = (alu_a >= alu_b);
  end

  assign ptr_idx  = AW'(TABLE_PTR_BASE) + AW'(pid_q);
  assign raw_addr = {rdata_q, vaddr_q[7:0]};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_idx] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_idx];
  end

  always_comb begin
    state_d      = state_q;
    ret_d        = ret_q;
    clr_d        = clr_q;
    req_d        = req_q;
    pid_d        = pid_q;
    count_d      = count_q;
    vaddr_d      = vaddr_q;
    sdata_d      = sdata_q;
    addr_d       = addr_q;
    scan_d       = scan_q;
    phase_tbl_d  = phase_tbl_q;
    tbl_d        = tbl_q;
    page_d       = page_q;
    idx_d        = idx_q;
    status_d     = status_q;
    phys_d       = phys_q;
    ldata_d      = ldata_q;
    out_valid_d  = out_valid_q & ~m_axis_tready;
    out_status_d = out_status_q;
    out_phys_d   = out_phys_q;
    out_ldata_d  = out_ldata_q;
    mem_idx      = addr_q[AW-1:0];
    mem_we       = 1'b0;
    mem_wdata    = 8'd0;

    case (state_q)
      S_CLEAR: begin
        mem_idx   = clr_q;
        mem_we    = 1'b1;
        mem_wdata = (clr_q == '0) ? 8'd1 : 8'd0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(MEM_BYTES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          req_d    = s_axis_tuser;
          pid_d    = s_axis_tdata[5:0];
          count_d  = s_axis_tdata[12:6];
          vaddr_d  = s_axis_tdata[26:13];
          sdata_d  = s_axis_tdata[34:27];
          status_d = STS_OK;
          phys_d   = '0;
          ldata_d  = '0;
          state_d  = S_PID;
        end
      end
      S_PID: begin
        if (alu_ge) begin
          pid_d = alu_diff[5:0];
        end else if (req_q == REQ_NEW) begin
          scan_d      = '0;
          phase_tbl_d = 1'b1;
          state_d     = S_SCAN_RD;
        end else begin
          state_d = S_PTR_RD;
        end
      end
      S_PTR_RD: begin
        mem_idx = ptr_idx;
        state_d = S_PTR_WT;
      end
      S_PTR_WT: begin
        tbl_d = rdata_q;
        if (req_q == REQ_KILL) begin
          if (rdata_q == 8'd0) begin
            status_d = STS_NO_KILL;
            state_d  = S_DONE;
          end else begin
            idx_d   = '0;
            addr_d  = {rdata_q, 8'd0};
            ret_d   = S_KILL_RD;
            state_d = MEM_POW2 ? S_KILL_RD : S_RED;
          end
        end else begin
          addr_d  = {rdata_q, 2'b00, vaddr_q[13:8]};
          ret_d   = S_TBL_RD;
          state_d = MEM_POW2 ? S_TBL_RD : S_RED;
        end
      end
      S_SCAN_RD: begin
        mem_idx = AW'(scan_q);
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        mem_idx = AW'(scan_q);
        if (rdata_q == 8'd0) begin
          mem_we    = 1'b1;
          mem_wdata = 8'd1;
          if (phase_tbl_q) begin
            tbl_d   = 8'(scan_q);
            state_d = S_PTR_WR;
          end else begin
            page_d  = scan_q;
            addr_d  = {tbl_q, 8'(idx_q)};
            ret_d   = S_ENT_WR;
            state_d = MEM_POW2 ? S_ENT_WR : S_RED;
          end
        end else if (scan_q == PGW'(PAGES - 1)) begin
          status_d = phase_tbl_q ? STS_NO_TABLE : STS_NO_DATA;
          state_d  = S_DONE;
        end else begin
          scan_d  = scan_q + PGW'(1);
          state_d = S_SCAN_RD;
        end
      end
      S_PTR_WR: begin
        mem_idx   = ptr_idx;
        mem_we    = 1'b1;
        mem_wdata = tbl_q;
        idx_d     = '0;
        if (count_q == 7'd0) begin
          state_d = S_DONE;
        end else begin
          scan_d      = '0;
          phase_tbl_d = 1'b0;
          state_d     = S_SCAN_RD;
        end
      end
      S_ENT_WR: begin
        mem_we    = 1'b1;
        mem_wdata = 8'(page_q);
        if (idx_q + 7'd1 == count_q) begin
          state_d = S_DONE;
        end else begin
          idx_d   = idx_q + 7'd1;
          scan_d  = '0;
          state_d = S_SCAN_RD;
        end
      end
      S_RED: begin
        if (!MEM_POW2 && alu_ge) begin
          addr_d = alu_diff[RAW_AW-1:0];
        end else begin
          state_d = ret_q;
        end
      end
      S_TBL_RD: begin
        state_d = S_TBL_WT;
      end
      S_TBL_WT: begin
        phys_d  = raw_addr[13:0];
        addr_d  = raw_addr;
        ret_d   = S_DAT;
        state_d = MEM_POW2 ? S_DAT : S_RED;
      end
      S_DAT: begin
        if (req_q == REQ_STORE) begin
          mem_we    = 1'b1;
          mem_wdata = sdata_q;
          state_d   = S_DONE;
        end else begin
          state_d = S_DAT_WT;
        end
      end
      S_DAT_WT: begin
        ldata_d = rdata_q;
        state_d = S_DONE;
      end
      S_KILL_RD: begin
        state_d = S_KILL_WT;
      end
      S_KILL_WT: begin
        mem_idx = AW'(rdata_q);
        if (rdata_q != 8'd0 && 9'(rdata_q) < 9'(PAGES)) begin
          mem_we = 1'b1;
        end
        if (idx_q == 7'(VIRT_PAGES - 1)) begin
          state_d = S_FREE_TBL;
        end else begin
          idx_d   = idx_q + 7'd1;
          addr_d  = {tbl_q, 8'(idx_q + 7'd1)};
          ret_d   = S_KILL_RD;
          state_d = MEM_POW2 ? S_KILL_RD : S_RED;
        end
      end
      S_FREE_TBL: begin
        mem_idx = AW'(tbl_q);
        mem_we  = (9'(tbl_q) < 9'(PAGES));
        state_d = S_CLR_PTR;
      end
      S_CLR_PTR: begin
        mem_idx = ptr_idx;
        mem_we  = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_phys_d   = phys_q;
          out_ldata_d  = ldata_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      ret_q       <= S_IDLE;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    pid_q        <= pid_d;
    count_q      <= count_d;
    vaddr_q      <= vaddr_d;
    sdata_q      <= sdata_d;
    addr_q       <= addr_d;
    scan_q       <= scan_d;
    phase_tbl_q  <= phase_tbl_d;
    tbl_q        <= tbl_d;
    page_q       <= page_d;
    idx_q        <= idx_d;
    status_q     <= status_d;
    phys_q       <= phys_d;
    ldata_q      <= ldata_d;
    out_status_q <= out_status_d;
    out_phys_q   <= out_phys_d;
    out_ldata_q  <= out_ldata_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_ldata_q, out_phys_q, out_status_q};

  // An accepted beat always starts with the process number reduction.
  a_accept_to_pid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> state_q == S_PID)
    else $error("accepted beat did not start the sequencer");

  // A new result is loaded only from the completion state.
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result appeared outside completion");

  // Without a power-of-two memory, every access through the address register
  // uses a reduced address.
  a_addr_wrapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !MEM_POW2 &&
    (state_q == S_TBL_RD || state_q == S_DAT || state_q == S_KILL_RD ||
     state_q == S_ENT_WR) |-> (17'(addr_q) < 17'(MEM_BYTES)))
    else $error("memory accessed with unwrapped address");

  // A missing table is reported only for a kill request.
  a_no_kill_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && status_q == STS_NO_KILL |-> req_q == REQ_KILL)
    else $error("kill status on a non-kill request");

endmodule

@@ bench/pmm_reply_checker.sv @@
// Reply checker for the paged memory manager: keeps its own copy of the byte
// memory, predicts the reply to every accepted request beat and compares it
// with the replies in order. Depends on pmm_pkg.

module pmm_reply_checker
  import pmm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // process_id[5:0], num_pages[12:6], virt_addr[26:13], store_data[34:27]
  input  logic [39:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], phys_addr[15:2], load_data[23:16]
  input  logic [23:0] m_axis_tdata,
  output int unsigned mismatches_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [7:0]  load_data;
    logic [13:0] phys_addr;
    logic [1:0]  status;
  } reply_t;

  localparam int unsigned MemBytes = MEM_BYTES_DFLT;

  logic [7:0]  shadow_mem [MemBytes];
  reply_t      expected_q [$];
  reply_t      seen_reply;
  reply_t      want_reply;
  reply_t      next_reply;
  int unsigned reply_num;
  int unsigned errors = 0;

  assign mismatches_o = errors;

  task automatic report_mismatch(input string msg);
    errors++;
    $display("reply %0d: %s", reply_num, msg);
  endtask

  function automatic int unsigned mem_at(input int unsigned page, input int unsigned offset);
    return (page * PAGE_BYTES + offset) % MemBytes;
  endfunction

  // First fit: the lowest page that the free map shows as free.
  task automatic claim_page(output logic [7:0] page, output bit ok);
    ok = 1'b0;
    page = '0;
    for (int i = 0; i < PAGES_DFLT && !ok; i++) begin
      if (shadow_mem[i] == 8'd0) begin
        shadow_mem[i] = 8'd1;
        page = 8'(i);
        ok = 1'b1;
      end
    end
  endtask

  task automatic return_page(input logic [7:0] page);
    if (page != 8'd0 && page < PAGES_DFLT) begin
      shadow_mem[page] = 8'd0;
    end
  endtask

  task automatic serve_request(input logic [1:0] kind, input logic [39:0] fields,
                               output reply_t reply);
    logic [5:0]  pid;
    logic [6:0]  count;
    logic [13:0] vaddr;
    logic [7:0]  wdata;
    logic [7:0]  table_pg;
    logic [7:0]  page;
    int unsigned ptr;
    int unsigned addr;
    bit          ok;
    pid   = fields[5:0];
    count = fields[12:6];
    vaddr = fields[26:13];
    wdata = fields[34:27];
    reply = '0;
    ptr   = TABLE_PTR_BASE + pid;
    case (kind)
      REQ_NEW: begin
        claim_page(table_pg, ok);
        if (!ok) begin
          reply.status = STS_NO_TABLE;
        end else begin
          shadow_mem[ptr] = table_pg;
          for (int i = 0; i < count && ok; i++) begin
            claim_page(page, ok);
            if (ok) begin
              shadow_mem[mem_at(table_pg, i)] = page;
            end else begin
              reply.status = STS_NO_DATA;
            end
          end
        end
      end
      REQ_KILL: begin
        table_pg = shadow_mem[ptr];
        if (table_pg == 8'd0) begin
          reply.status = STS_NO_KILL;
        end else begin
          for (int i = 0; i < VIRT_PAGES; i++) begin
            return_page(shadow_mem[mem_at(table_pg, i)]);
          end
          return_page(table_pg);
          shadow_mem[ptr] = 8'd0;
        end
      end
      default: begin
        // Without a table the pointer reads zero and page 0 serves as the table.
        table_pg = shadow_mem[ptr];
        page = shadow_mem[mem_at(table_pg, vaddr[13:8])];
        addr = mem_at(page, vaddr[7:0]);
        reply.phys_addr = addr[13:0];
        if (kind == REQ_STORE) begin
          shadow_mem[addr] = wdata;
        end else begin
          reply.load_data = shadow_mem[addr];
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (shadow_mem[i]) shadow_mem[i] = 8'd0;
      shadow_mem[0] = 8'd1;
      expected_q.delete();
      reply_num = 0;
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen_reply = m_axis_tdata;
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("beat 0x%06h with no request outstanding", m_axis_tdata));
        end else begin
          want_reply = expected_q.pop_front();
          if (seen_reply.status != want_reply.status) begin
            report_mismatch($sformatf("status expected %0d, got %0d",
                                      want_reply.status, seen_reply.status));
          end
          if (seen_reply.phys_addr != want_reply.phys_addr) begin
            report_mismatch($sformatf("phys_addr expected 0x%04h, got 0x%04h",
                                      want_reply.phys_addr, seen_reply.phys_addr));
          end
          if (seen_reply.load_data != want_reply.load_data) begin
            report_mismatch($sformatf("load_data expected 0x%02h, got 0x%02h",
                                      want_reply.load_data, seen_reply.load_data));
          end
        end
        reply_num++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        serve_request(s_axis_tuser, s_axis_tdata, next_reply);
        expected_q.push_back(next_reply);
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

@@ bench/tb_paged_memory_manager_unit.sv @@
// Testbench top for the paged memory manager: drives directed and random
// requests under changing back pressure and gives the verdict. Depends on
// pmm_pkg, paged_memory_manager_unit and pmm_reply_checker.

module tb_paged_memory_manager_unit;
  import pmm_pkg::*;

  localparam int unsigned CycleLimit   = 16_000_000;
  localparam int unsigned RandomItems  = 400;
  localparam int unsigned SettleCycles = 64;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned send_gap_pct = 36;
  int unsigned recv_gap_pct = 56;

  // Rough bookkeeping of the processes alive, used only to shape requests.
  bit          live [64];
  int unsigned pages_of [64];
  int unsigned pages_booked;
  bit          have_last;
  logic [5:0]  last_pid;
  logic [13:0] last_vaddr;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  paged_memory_manager_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  pmm_reply_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
  end

  task automatic send_request(input logic [1:0] kind, input logic [5:0] pid,
                              input logic [6:0] count, input logic [13:0] vaddr,
                              input logic [7:0] wdata);
    if ($urandom_range(0, 99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_gap_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {5'd0, wdata, vaddr, count, pid};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic bit find_pid(input bit want_live, input bit need_pages,
                                  output logic [5:0] pid);
    int unsigned start;
    start = $urandom_range(0, 63);
    pid = '0;
    for (int k = 0; k < 64; k++) begin
      pid = 6'(start + k);
      if (live[pid] == want_live && (!need_pages || pages_of[pid] != 0)) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic issue_random_request();
    logic [1:0]  kind;
    logic [5:0]  pid;
    logic [6:0]  count;
    logic [13:0] vaddr;
    logic [7:0]  wdata;
    int unsigned pick;
    bit          can_new;
    kind  = 2'($urandom);
    pid   = 6'($urandom);
    count = 7'($urandom);
    vaddr = 14'($urandom);
    wdata = 8'($urandom);
    pick  = $urandom_range(0, 99);
    if (pick < 8) begin
      // Stray request with random fields; stores stay rare since an untranslated
      // one can land in the free map or the table pointers.
      if (kind == REQ_STORE && $urandom_range(0, 3) != 0) begin
        kind = REQ_LOAD;
      end
    end else begin
      count = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(5, 24))
                                          : 7'($urandom_range(0, 4));
      can_new = (pages_booked + 1 + count < PAGES_DFLT);
      if (pick < 35 && can_new && find_pid(1'b0, 1'b0, pid)) begin
        kind = REQ_NEW;
      end else if (pick < 80 && find_pid(1'b1, 1'b1, pid)) begin
        kind = $urandom_range(0, 1) ? REQ_STORE : REQ_LOAD;
        vaddr[13:8] = 6'($urandom_range(0, pages_of[pid] - 1));
        if (kind == REQ_LOAD && have_last && live[last_pid] && $urandom_range(0, 2) == 0) begin
          pid   = last_pid;
          vaddr = last_vaddr;
        end
        if (kind == REQ_STORE) begin
          have_last  = 1'b1;
          last_pid   = pid;
          last_vaddr = vaddr;
        end
      end else if (find_pid(1'b1, 1'b0, pid)) begin
        kind = REQ_KILL;
      end else if (can_new && find_pid(1'b0, 1'b0, pid)) begin
        kind = REQ_NEW;
      end else begin
        kind = REQ_LOAD;
      end
    end
    if (kind == REQ_NEW) begin
      pages_of[pid] = (count > VIRT_PAGES) ? VIRT_PAGES : count;
      pages_booked += 1 + pages_of[pid];
      live[pid] = 1'b1;
    end else if (kind == REQ_KILL && live[pid]) begin
      pages_booked = (pages_booked > pages_of[pid]) ? pages_booked - 1 - pages_of[pid] : 0;
      live[pid] = 1'b0;
      pages_of[pid] = 0;
    end
    send_request(kind, pid, count, vaddr, wdata);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Translation and kill with no table present.
    send_request(REQ_LOAD,  6'd5,  7'd0,   14'h0000,        8'h00);
    send_request(REQ_KILL,  6'd7,  7'd0,   14'h0000,        8'h00);
    send_request(REQ_NEW,   6'd0,  7'd0,   14'h0000,        8'h00);
    send_request(REQ_NEW,   6'd63, 7'd3,   14'h0000,        8'h00);
    send_request(REQ_STORE, 6'd63, 7'd0,   {6'd0, 8'h00},   8'hFF);
    send_request(REQ_STORE, 6'd63, 7'd0,   {6'd2, 8'hFF},   8'h00);
    send_request(REQ_STORE, 6'd63, 7'd0,   {6'd1, 8'h55},   8'hAA);
    send_request(REQ_LOAD,  6'd63, 7'd0,   {6'd0, 8'h00},   8'h00);
    send_request(REQ_LOAD,  6'd63, 7'd0,   {6'd2, 8'hFF},   8'h00);
    send_request(REQ_LOAD,  6'd63, 7'd0,   {6'd1, 8'h55},   8'h00);
    // Untranslated store into the unused tail of page zero, then read back.
    send_request(REQ_STORE, 6'd10, 7'd0,   14'h3FFF,        8'h5A);
    send_request(REQ_LOAD,  6'd10, 7'd0,   14'h3FFF,        8'h00);
    // A second new process on a live number leaks its old table page.
    send_request(REQ_NEW,   6'd0,  7'd2,   14'h0000,        8'h00);
    send_request(REQ_STORE, 6'd0,  7'd0,   {6'd1, 8'h2A},   8'h55);
    send_request(REQ_LOAD,  6'd0,  7'd0,   {6'd1, 8'h2A},   8'h00);
    send_request(REQ_KILL,  6'd63, 7'd0,   14'h0000,        8'h00);
    send_request(REQ_KILL,  6'd0,  7'd0,   14'h0000,        8'h00);
    // Running out of data pages, then out of table pages.
    send_request(REQ_NEW,   6'd42, 7'd127, 14'h0000,        8'h00);
    send_request(REQ_NEW,   6'd21, 7'd64,  14'h0000,        8'h00);
    send_request(REQ_LOAD,  6'd42, 7'd0,   {6'd60, 8'h80},  8'h00);
    send_request(REQ_KILL,  6'd42, 7'd0,   14'h0000,        8'h00);
    send_request(REQ_KILL,  6'd21, 7'd0,   14'h0000,        8'h00);
    // Exact fit of every page that is still free.
    send_request(REQ_NEW,   6'd21, 7'd61,  14'h0000,        8'h00);
    send_request(REQ_KILL,  6'd21, 7'd0,   14'h0000,        8'h00);
    pages_booked = 1;

    for (int phase = 0; phase < 3; phase++) begin
      wait_drained();
      send_gap_pct = (phase == 0) ? 36 : (phase == 1) ? 56 : 0;
      recv_gap_pct = (phase == 0) ? 56 : (phase == 1) ? 36 : 0;
      for (int n = 0; n < RandomItems / 3; n++) begin
        issue_random_request();
      end
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/pmm_pkg.sv
hw/rtl/paged_memory_manager_unit.sv
bench/pmm_reply_checker.sv
bench/tb_paged_memory_manager_unit.sv
